@@ rtl/core/adsr_pkg.sv @@
// ============================================================================
// adsr_pkg - shared types and constants of the exponential envelope generator
// fixed-point limits, phase and sequencer codes, multiplier status bundle
// ============================================================================
package adsr_pkg;

    // fixed-point widths
    localparam int LEVEL_W = 24;   // Q1.23 level, sustain
    localparam int COEF_W  = 24;   // Q0.24 coefficients
    localparam int VEL_W   = 16;   // Q1.15 velocity and output
    localparam int MUL_W   = 24;   // width of both multiplier operands

    localparam logic [LEVEL_W-1:0] LEVEL_ONE     = 24'd8388608;
    localparam logic [LEVEL_W-1:0] ATTACK_DONE   = 24'd8380219;  // just under 0.999
    localparam logic [LEVEL_W-1:0] RELEASE_FLOOR = 24'd84;       // just over 1e-5
    localparam logic [VEL_W-1:0]   VEL_ONE       = 16'd32768;

    // configuration register reset values
    localparam logic [COEF_W-1:0]  ATTACK_RST  = 24'd16742299;
    localparam logic [COEF_W-1:0]  DECAY_RST   = 24'd16773721;
    localparam logic [COEF_W-1:0]  RELEASE_RST = 24'd16775468;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 24'd4194304;

    // configuration register indexes
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;
    localparam logic [1:0] REG_SUSTAIN = 2'd3;

    // input beat kinds
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_DECAY   = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_READY,
        ST_MUL_STEP,
        ST_UPDATE,
        ST_MUL_OUT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

@@ rtl/core/adsr_ser_mul.sv @@
// ============================================================================
// adsr_ser_mul - bit-serial shift-add multiplier
// one multiplier bit per cycle, lsb first; done pulses high for a single cycle, registered with the last
// ============================================================================
module adsr_ser_mul #(
    parameter int WA = 24,
    parameter int WB = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WA-1:0]        i_a,
    input  logic [WB-1:0]        i_b,
    output adsr_pkg::t_mul_stat  o_stat,
    output logic [WA+WB-1:0]     o_prod
);

    localparam int CW = (WB > 1) ? $clog2(WB) : 1;
    localparam logic [CW-1:0] LAST = CW'(WB - 1);

    logic [WA-1:0] r_a;
    logic [WA-1:0] r_hi;
    logic [WB-1:0] r_lo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [WA:0]   w_sum;

    // partial sum of the current digit
    always_comb begin
        w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(WA+1){1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[WA:1];
                r_lo  <= {w_sum[0], r_lo[WB-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = {r_hi, r_lo};

endmodule

@@ rtl/core/exponential_adsr_envelope.sv @@
// ============================================================================
// exponential_adsr_envelope - exponential attack/decay/release envelope
// sequence: a sample tick runs the step pass, the level update and the output
//   pass, then its beat is registered; note on, note off and the unused kind
//   are taken in the ready state and give no beat; no beat is taken while a
//   tick is in flight: two passes through the single bit-serial multiplier
//   (step shrink, then level times velocity), longer while an output beat waits
// reset: synchronous active low; idle phase, level 0, velocity 1.0, default
//   coefficients and sustain 0.5; no output beat pending
// ============================================================================
module exponential_adsr_envelope (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] note_velocity
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    // output beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] envelope_out, [17:16] phase, rest zero
);

    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int MW = adsr_pkg::MUL_W;
    localparam int VW = adsr_pkg::VEL_W;

    // configuration registers
    logic [LW-1:0] r_attack_coef;
    logic [LW-1:0] r_decay_coef;
    logic [LW-1:0] r_release_coef;
    logic [LW-1:0] r_sustain;

    // envelope state
    adsr_pkg::t_phase r_phase, n_phase;
    logic [LW-1:0]    r_level, n_level;
    logic [VW-1:0]    r_velocity;

    // step operands kept for the update cycle
    logic [LW-1:0]    r_target;
    logic             r_up;

    // sequencer
    adsr_pkg::t_state r_state, n_state;

    // output register
    logic             r_out_valid;
    logic [VW-1:0]    r_out_env;
    adsr_pkg::t_phase r_out_phase;

    // multiplier
    adsr_pkg::t_mul_stat w_mul_stat;
    logic [2*MW-1:0]     w_mul_prod;
    logic                w_mul_start;
    logic [MW-1:0]       w_mul_a;
    logic [MW-1:0]       w_mul_b;

    // control strobes
    logic w_in_beat;
    logic w_tick;
    logic w_step_start;
    logic w_update;
    logic w_emit;
    logic w_out_free;

    // step set-up from the present phase
    logic [LW-1:0] w_target;
    logic [LW-1:0] w_coef;
    logic          w_up;
    logic [LW-1:0] w_dist;

    // update and rounding
    logic [LW-1:0] w_shrink;
    logic [LW-1:0] w_stepped;
    logic [39:0]   w_round;
    logic [VW-1:0] w_vel_sat;

    adsr_ser_mul #(
        .WA (MW),
        .WB (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_stat  (w_mul_stat),
        .o_prod  (w_mul_prod)
    );

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_tick     = w_in_beat && (s_axis_tuser == adsr_pkg::OP_TICK);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // target and coefficient of the present phase; idle and release both aim at zero
    always_comb begin
        case (r_phase)
            adsr_pkg::PH_ATTACK: begin
                w_target = adsr_pkg::LEVEL_ONE;
                w_coef   = r_attack_coef;
            end
            adsr_pkg::PH_DECAY: begin
                w_target = r_sustain;
                w_coef   = r_decay_coef;
            end
            default: begin
                w_target = '0;
                w_coef   = r_release_coef;
            end
        endcase
        w_up   = (r_level >= w_target);
        w_dist = w_up ? (r_level - w_target) : (w_target - r_level);
    end

    // new level and phase once the shrunk distance is ready
    always_comb begin
        w_shrink  = w_mul_prod[2*MW-1:MW];
        w_stepped = r_up ? (r_target + w_shrink) : (r_target - w_shrink);
        n_level   = w_stepped;
        n_phase   = r_phase;
        case (r_phase)
            adsr_pkg::PH_ATTACK: begin
                if (w_stepped > adsr_pkg::ATTACK_DONE) begin
                    n_level = adsr_pkg::LEVEL_ONE;
                    n_phase = adsr_pkg::PH_DECAY;
                end
            end
            adsr_pkg::PH_DECAY: begin
                n_level = w_stepped;
            end
            adsr_pkg::PH_RELEASE: begin
                if (w_stepped < adsr_pkg::RELEASE_FLOOR) begin
                    n_level = '0;
                    n_phase = adsr_pkg::PH_IDLE;
                end
            end
            default: begin
                n_level = '0;
            end
        endcase
    end

    // round level times velocity to q1.15
    assign w_round   = {1'b0, w_mul_prod[38:0]} + 40'd4194304;
    assign w_vel_sat = (s_axis_tdata > adsr_pkg::VEL_ONE) ? adsr_pkg::VEL_ONE : s_axis_tdata;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            adsr_pkg::ST_READY: begin
                if (w_tick) begin
                    n_state = adsr_pkg::ST_MUL_STEP;
                end
            end
            adsr_pkg::ST_MUL_STEP: begin
                if (w_mul_stat.done) begin
                    n_state = adsr_pkg::ST_UPDATE;
                end
            end
            adsr_pkg::ST_UPDATE: begin
                n_state = adsr_pkg::ST_MUL_OUT;
            end
            adsr_pkg::ST_MUL_OUT: begin
                if (w_mul_stat.done) begin
                    n_state = adsr_pkg::ST_EMIT;
                end
            end
            adsr_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = adsr_pkg::ST_READY;
                end
            end
            default: begin
                n_state = adsr_pkg::ST_READY;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_step_start  = 1'b0;
        w_update      = 1'b0;
        w_emit        = 1'b0;
        case (r_state)
            adsr_pkg::ST_READY: begin
                s_axis_tready = 1'b1;
                w_step_start  = w_tick;
            end
            adsr_pkg::ST_UPDATE: begin
                w_update = 1'b1;
            end
            adsr_pkg::ST_EMIT: begin
                w_emit = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // first pass shrinks the distance, second scales the new level by velocity
    assign w_mul_start = w_step_start || w_update;
    assign w_mul_a     = w_update ? n_level : w_dist;
    assign w_mul_b     = w_update ? {{(MW-VW){1'b0}}, r_velocity} : w_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= adsr_pkg::ST_READY;
            r_phase        <= adsr_pkg::PH_IDLE;
            r_level        <= '0;
            r_velocity     <= adsr_pkg::VEL_ONE;
            r_attack_coef  <= adsr_pkg::ATTACK_RST;
            r_decay_coef   <= adsr_pkg::DECAY_RST;
            r_release_coef <= adsr_pkg::RELEASE_RST;
            r_sustain      <= adsr_pkg::SUSTAIN_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    adsr_pkg::REG_ATTACK:  r_attack_coef  <= i_cfg_data;
                    adsr_pkg::REG_DECAY:   r_decay_coef   <= i_cfg_data;
                    adsr_pkg::REG_RELEASE: r_release_coef <= i_cfg_data;
                    adsr_pkg::REG_SUSTAIN: begin
                        r_sustain <= (i_cfg_data > adsr_pkg::LEVEL_ONE) ?
                                     adsr_pkg::LEVEL_ONE : i_cfg_data;
                    end
                    default: r_sustain <= r_sustain;
                endcase
            end

            // note events act at once, from whatever level is present
            if (w_in_beat && (s_axis_tuser == adsr_pkg::OP_NOTE_ON)) begin
                r_velocity <= w_vel_sat;
                r_phase    <= adsr_pkg::PH_ATTACK;
            end
            if (w_in_beat && (s_axis_tuser == adsr_pkg::OP_NOTE_OFF) &&
                (r_phase != adsr_pkg::PH_IDLE)) begin
                r_phase <= adsr_pkg::PH_RELEASE;
            end

            if (w_update) begin
                r_level <= n_level;
                r_phase <= n_phase;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_step_start) begin
            r_target <= w_target;
            r_up     <= w_up;
        end
        if (w_emit) begin
            r_out_env   <= w_round[38:23];
            r_out_phase <= r_phase;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_phase, r_out_env};

    // the multiplier is only started when it is free
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_stat.busy)
        else $error("multiplier started while busy");

    // taking beats only while no tick is in flight
    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!w_mul_stat.busy && !w_mul_stat.done))
        else $error("input taken while a tick is in flight");

    // the level never rises above full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= adsr_pkg::LEVEL_ONE)
        else $error("level above full scale");

    // an idle beat always carries silence
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_phase == adsr_pkg::PH_IDLE)) |-> (r_out_env == '0))
        else $error("idle beat not silent");

endmodule

@@ verif/exponential_adsr_envelope_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// exponential_adsr_envelope_test - self-checking bench for the envelope block
// drives note on, note off and sample tick beats in random bursts, predicts
// every output beat with a bit-true envelope model and checks it field by field
// ============================================================================
module exponential_adsr_envelope_test;

    // the fourth op code has no name in the package; the block drops it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 7;
    localparam int TICK_LATENCY  = 52;               // delay from a taken tick to its output beat
    localparam int SETTLE_CYCLES = 2 * TICK_LATENCY;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PHASE_ITEMS   = 180;
    localparam int REPORT_CAP    = 40;

    // one input beat: op travels in tuser, velocity in tdata
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] velocity;
    } t_env_cmd;

    // one predicted output beat
    typedef struct packed {
        logic [15:0]      level_out;
        adsr_pkg::t_phase ph;
    } t_env_level;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = adsr_pkg::REG_ATTACK;
    logic [23:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [15:0] note_velocity
    logic [1:0]  s_axis_tuser  = adsr_pkg::OP_TICK; // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] envelope_out, [17:16] phase

    exponential_adsr_envelope u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns period
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // envelope prediction: own copy of registers and state
    // ------------------------------------------------------------------------
    logic [23:0] cfg_attack  = adsr_pkg::ATTACK_RST;
    logic [23:0] cfg_decay   = adsr_pkg::DECAY_RST;
    logic [23:0] cfg_release = adsr_pkg::RELEASE_RST;
    logic [23:0] cfg_sustain = adsr_pkg::SUSTAIN_RST;

    adsr_pkg::t_phase env_ph  = adsr_pkg::PH_IDLE;
    logic [23:0]      env_lvl = '0;
    logic [15:0]      env_vel = adsr_pkg::VEL_ONE;

    t_env_cmd    cmd_backlog[$];   // beats still to be offered
    t_env_level  due_levels[$];    // output beats predicted, oldest first

    int cmds_queued   = 0;
    int cmds_accepted = 0;
    int levels_seen   = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    // distance times coefficient, Q0.24 product truncated
    function automatic logic [23:0] scale_dist(input logic [23:0] distance,
                                               input logic [23:0] coef);
        logic [47:0] prod;
        prod = {24'd0, distance} * {24'd0, coef};
        return prod[47:24];
    endfunction

    // one-pole step toward the target, never overshooting it
    function automatic logic [23:0] approach(input logic [23:0] lvl,
                                             input logic [23:0] target,
                                             input logic [23:0] coef);
        if (lvl >= target)
            return target + scale_dist(lvl - target, coef);
        return target - scale_dist(target - lvl, coef);
    endfunction

    task automatic advance_envelope(input t_env_cmd cmd);
        logic [39:0] prod;
        t_env_level  nxt;
        case (cmd.op)
            adsr_pkg::OP_NOTE_ON: begin
                // velocity above 1.0 is clipped when stored
                env_vel = (cmd.velocity > adsr_pkg::VEL_ONE) ? adsr_pkg::VEL_ONE
                                                             : cmd.velocity;
                env_ph  = adsr_pkg::PH_ATTACK;
            end
            adsr_pkg::OP_NOTE_OFF: begin
                if (env_ph != adsr_pkg::PH_IDLE)
                    env_ph = adsr_pkg::PH_RELEASE;
            end
            adsr_pkg::OP_TICK: begin
                case (env_ph)
                    adsr_pkg::PH_ATTACK: begin
                        env_lvl = approach(env_lvl, adsr_pkg::LEVEL_ONE, cfg_attack);
                        if (env_lvl > adsr_pkg::ATTACK_DONE) begin
                            env_lvl = adsr_pkg::LEVEL_ONE;
                            env_ph  = adsr_pkg::PH_DECAY;
                        end
                    end
                    adsr_pkg::PH_DECAY: begin
                        env_lvl = approach(env_lvl, cfg_sustain, cfg_decay);
                    end
                    adsr_pkg::PH_RELEASE: begin
                        env_lvl = scale_dist(env_lvl, cfg_release);
                        if (env_lvl < adsr_pkg::RELEASE_FLOOR) begin
                            env_lvl = '0;
                            env_ph  = adsr_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        env_lvl = '0;
                    end
                endcase
                // level times velocity, rounded half up from Q2.38 to Q1.15
                prod = {16'd0, env_lvl} * {24'd0, env_vel};
                prod = prod + 40'd4194304;
                nxt.level_out = prod[38:23];
                nxt.ph        = env_ph;
                due_levels.push_back(nxt);
            end
            default: begin
                // unused op code: no state change, no beat
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("envelope check: %s got %0d expected %0d (output beat %0d)",
                     what, got, want, levels_seen);
    endtask

    // ------------------------------------------------------------------------
    // input side and output side observed at the rising edge
    // ------------------------------------------------------------------------
    logic       cmd_taken = 1'b0;
    t_env_level got_level;

    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            advance_envelope({s_axis_tuser, s_axis_tdata});
            cmds_accepted++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            levels_seen++;
            if (due_levels.size() == 0) begin
                report_mismatch("output beat with nothing due, tdata", m_axis_tdata, 0);
            end else begin
                got_level = due_levels.pop_front();
                if (m_axis_tdata[15:0] != got_level.level_out)
                    report_mismatch("envelope_out", m_axis_tdata[15:0], got_level.level_out);
                if (m_axis_tdata[17:16] != got_level.ph)
                    report_mismatch("phase", m_axis_tdata[17:16], got_level.ph);
                if (m_axis_tdata[23:18] != '0)
                    report_mismatch("padding bits", m_axis_tdata[23:18], 0);
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender: bursts of back-to-back beats separated by random gaps
    // ------------------------------------------------------------------------
    int       burst_left = 1;
    int       gap_left   = 0;
    t_env_cmd next_cmd;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || cmd_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                next_cmd = cmd_backlog.pop_front();
                s_axis_tuser  <= next_cmd.op;
                s_axis_tdata  <= next_cmd.velocity;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // new burst; a quarter of them follow on with no gap
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: ready duty cycle is redrawn periodically, and once
    // a long hold-off lets the output beat back up into the input
    // ------------------------------------------------------------------------
    int rx_cycle  = 0;
    int ready_pct = 100;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 300 == 0) begin
            case ($urandom_range(0, 2))
                0:       ready_pct = 100;
                1:       ready_pct = 70;
                default: ready_pct = 25;
            endcase
        end
        if (!hold_done && levels_seen >= 100 && cmd_backlog.size() > 40) begin
            hold_left = 600;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cmd(input logic [1:0] op, input logic [15:0] velocity);
        t_env_cmd c;
        c.op       = op;
        c.velocity = velocity;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // register writes only while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            adsr_pkg::REG_ATTACK:  cfg_attack  = val;
            adsr_pkg::REG_DECAY:   cfg_decay   = val;
            adsr_pkg::REG_RELEASE: cfg_release = val;
            default: cfg_sustain = (val > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE : val;
        endcase
    endtask

    task automatic write_all(input logic [23:0] atk, input logic [23:0] dec,
                             input logic [23:0] rel, input logic [23:0] sus);
        write_reg(adsr_pkg::REG_ATTACK, atk);
        write_reg(adsr_pkg::REG_DECAY, dec);
        write_reg(adsr_pkg::REG_RELEASE, rel);
        write_reg(adsr_pkg::REG_SUSTAIN, sus);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // every beat taken and every output beat back, then let the block settle
    task automatic wait_drained();
        while (cmds_accepted != cmds_queued || due_levels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly time constants of a few to a few hundred ticks, plus the extremes
    function automatic logic [23:0] random_coef();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            default: return 24'(32'hFFFFFF -
                                ($urandom & ((32'd1 << $urandom_range(22, 16)) - 1)));
        endcase
    endfunction

    function automatic logic [23:0] random_sustain();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return adsr_pkg::LEVEL_ONE;
            // clipped to 1.0
            2:       return 24'($urandom_range(adsr_pkg::LEVEL_ONE + 1, 24'hFFFFFF));
            default: return 24'($urandom_range(0, adsr_pkg::LEVEL_ONE));
        endcase
    endfunction

    function automatic logic [15:0] random_velocity();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 16'hFFFF));
        return 16'($urandom_range(0, adsr_pkg::VEL_ONE));
    endfunction

    // note on, ticks, usually note off and more ticks; some random noise
    task automatic queue_note_sequences(input int budget, output int made);
        int k;
        int r;
        made = 0;
        while (made < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                push_cmd(adsr_pkg::OP_NOTE_ON, random_velocity());
                k = $urandom_range(1, 40);
                repeat (k) push_cmd(adsr_pkg::OP_TICK, 16'($urandom));
                made += k + 1;
                if ($urandom_range(0, 4) != 0) begin
                    push_cmd(adsr_pkg::OP_NOTE_OFF, 16'($urandom));
                    k = $urandom_range(1, 60);
                    repeat (k) push_cmd(adsr_pkg::OP_TICK, 16'($urandom));
                    made += k + 1;
                end
            end else begin
                k = $urandom_range(1, 6);
                repeat (k) begin
                    r = $urandom_range(0, 3);
                    push_cmd(r[1:0], 16'($urandom));
                    if (r[1:0] != OP_UNUSED)
                        made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    int random_done;
    int made;
    int setting;

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: idle ticks, ignored beats, clipped and zero velocity
        push_cmd(adsr_pkg::OP_TICK, 16'hFFFF);
        push_cmd(adsr_pkg::OP_NOTE_OFF, 16'h0000);
        push_cmd(OP_UNUSED, 16'hA5A5);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_NOTE_ON, 16'hFFFF);
        push_cmd(adsr_pkg::OP_TICK, 16'h5A5A);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_NOTE_OFF, 16'h0000);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_NOTE_ON, 16'h0000);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_NOTE_ON, adsr_pkg::VEL_ONE);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        wait_drained();

        // zero coefficients jump straight to each target; sustain over 1.0 clips
        write_all(24'd0, 24'd0, 24'd0, 24'hFFFFFF);
        push_cmd(adsr_pkg::OP_NOTE_ON, 16'd1);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_NOTE_ON, adsr_pkg::VEL_ONE);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_NOTE_OFF, 16'h0000);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        push_cmd(adsr_pkg::OP_NOTE_OFF, 16'h0000);
        push_cmd(adsr_pkg::OP_TICK, 16'h0000);
        wait_drained();

        // random phases, the first with the slowest coefficients possible
        random_done = 0;
        setting     = 0;
        while (random_done < RANDOM_ITEMS) begin
            if (setting == 0)
                write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, adsr_pkg::LEVEL_ONE);
            else
                write_all(random_coef(), random_coef(), random_coef(), random_sustain());
            queue_note_sequences(PHASE_ITEMS, made);
            random_done += made;
            wait_drained();
            setting++;
        end

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
